/* rtl/bootp_reply_checker_parser_top_macros.svh */
// Assertion helpers included by the top-level RTL
`ifndef BOOTP_REPLY_CHECKER_PARSER_TOP_MACROS_SVH
`define BOOTP_REPLY_CHECKER_PARSER_TOP_MACROS_SVH
// property that holds whenever reset is released
`define BRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define BRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/brp_pkg.sv */
`timescale 1ns / 1ps
package brp_pkg;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [15:0] OPT_START = 16'd268;
  localparam int          CFG_AW = 4;

  localparam logic [3:0] REG_XID = 4'd0;
  localparam logic [3:0] REG_NETMASK = 4'd4;
  localparam logic [3:0] REG_GATEWAY = 4'd8;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_REPLIED = 3'd1;
  localparam logic [2:0] ST_BAD_HDR = 3'd2;
  localparam logic [2:0] ST_FRAG = 3'd3;
  localparam logic [2:0] ST_NOT_OURS = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0, PH_CODE = 3'd1, PH_LEN = 3'd2, PH_DATA = 3'd3, PH_DONE = 3'd4
  } opt_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       other_host;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  status;
    logic [31:0] assigned_ip;
    logic [31:0] server_addr;
    logic [31:0] netmask;
    logic [31:0] gateway;
  } out_item_t;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'd99;
      2'd1: r = 8'd130;
      2'd2: r = 8'd83;
      default: r = 8'd99;
    endcase
    return r;
  endfunction
endpackage

/* rtl/brp_if.sv */
`timescale 1ns / 1ps
interface brp_in_if;
  import brp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface brp_out_if;
  import brp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/brp_cfg_regs.sv */
`timescale 1ns / 1ps
module brp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [brp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output logic [31:0]                xid,
  output logic [31:0]                preset_netmask,
  output logic [31:0]                preset_gateway
);
  import brp_pkg::*;
  logic [31:0] xid_r, mask_r, gw_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xid_r <= '0;
      mask_r <= ALL_ONES;
      gw_r <= ALL_ONES;
    end else if (wr) begin
      case (cfg_paddr)
        REG_XID:     xid_r <= cfg_pwdata;
        REG_NETMASK: mask_r <= cfg_pwdata;
        REG_GATEWAY: gw_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_XID:     cfg_prdata = xid_r;
      REG_NETMASK: cfg_prdata = mask_r;
      REG_GATEWAY: cfg_prdata = gw_r;
      default:     cfg_prdata = '0;
    endcase
  end

  assign xid = xid_r;
  assign preset_netmask = mask_r;
  assign preset_gateway = gw_r;
endmodule

/* rtl/bootp_reply_checker_parser_top.sv */
`timescale 1ns / 1ps
// The verdict for a packet is registered and offered in the cycle after its last byte is taken.
// Throughput: one byte per cycle unless a verdict is stalled; the per-byte parse is a single registered pass.
// The output register frees itself in the cycle it is taken, so bytes keep flowing.
// Reset (synchronous, rst_n low) clears parse state, reply_received and the output
// valid; registers return to xid 0 and all-ones preset netmask and gateway.
`include "bootp_reply_checker_parser_top_macros.svh"
module bootp_reply_checker_parser_top (
  input  logic                       clk,
  input  logic                       rst_n,
  brp_in_if.sink                     in_ch,
  brp_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [brp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import brp_pkg::*;

  logic [31:0] xid, pmask, pgw;
  brp_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .xid, .preset_netmask(pmask), .preset_gateway(pgw)
  );

  logic        replied_r, replied_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [16:0] sum_r, sum_nxt;
  logic        hfault_r, hfault_nxt, frag_r, frag_nxt, rfault_r, rfault_nxt;
  logic [15:0] tlen_r, tlen_nxt, ulen_r, ulen_nxt;
  logic [31:0] your_r, your_nxt, srv_r, srv_nxt, relay_r, relay_nxt;
  logic [31:0] mask_r, mask_nxt, gw_r, gw_nxt;
  opt_phase_t  ph_r, ph_nxt;
  logic [7:0]  code_r, code_nxt, rem_r, rem_nxt, held_r;
  logic [1:0]  flags_r, flags_nxt;
  logic [2:0]  taken_r, taken_nxt;
  logic        cookie_bad_r, cookie_bad_nxt;
  logic        ovalid_r;
  out_item_t   out_r, out_nxt;

  logic        take, first;
  logic [7:0]  b;
  logic [15:0] word;
  logic [16:0] s;
  logic [16:0] opt_end;
  logic [16:0] len;
  logic [16:0] ulen_p20;
  logic [2:0]  status;
  logic [4:0]  xid_sh;

  assign in_ch.ready = !ovalid_r || out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;
  assign b = in_ch.data.data_byte;
  assign first = (pos_r == 16'd0);
  assign word = {held_r, b};

  always_comb begin
    // start of packet: clear per-packet state before applying this byte
    sum_nxt = first ? 17'd0 : sum_r;
    hfault_nxt = first ? in_ch.data.other_host : hfault_r;
    frag_nxt = first ? 1'b0 : frag_r;
    rfault_nxt = first ? 1'b0 : rfault_r;
    tlen_nxt = first ? 16'd0 : tlen_r;
    ulen_nxt = first ? 16'd0 : ulen_r;
    your_nxt = first ? 32'd0 : your_r;
    srv_nxt = first ? 32'd0 : srv_r;
    relay_nxt = first ? 32'd0 : relay_r;
    mask_nxt = first ? pmask : mask_r;
    gw_nxt = first ? pgw : gw_r;
    ph_nxt = first ? PH_IDLE : ph_r;
    code_nxt = first ? 8'd0 : code_r;
    rem_nxt = first ? 8'd0 : rem_r;
    flags_nxt = first ? 2'd0 : flags_r;
    taken_nxt = first ? 3'd0 : taken_r;
    cookie_bad_nxt = first ? 1'b0 : cookie_bad_r;
    s = '0;
    opt_end = '0;

    if (pos_r < 16'd20 && pos_r[0]) begin
      s = sum_nxt + {1'b0, word};
      sum_nxt = {1'b0, s[15:0]} + {16'd0, s[16]};
    end
    if (pos_r == 16'd0 && b != 8'h45) hfault_nxt = 1'b1;
    if (pos_r == 16'd2 || pos_r == 16'd3) tlen_nxt = {tlen_nxt[7:0], b};
    if (pos_r == 16'd6 && b[5:0] != 6'd0) frag_nxt = 1'b1;
    if (pos_r == 16'd7 && b != 8'd0) frag_nxt = 1'b1;
    if (pos_r == 16'd9 && b != 8'd17) hfault_nxt = 1'b1;
    if (pos_r == 16'd21 && word != 16'd67) hfault_nxt = 1'b1;
    if (pos_r == 16'd23 && word != 16'd68) hfault_nxt = 1'b1;
    if (pos_r == 16'd24 || pos_r == 16'd25) ulen_nxt = {ulen_nxt[7:0], b};
    if (pos_r == 16'd28 && b != 8'd2) rfault_nxt = 1'b1;
    // xid bytes arrive most significant first at 32..35
    xid_sh = {(2'd3 - pos_r[1:0]), 3'd0};
    if (pos_r >= 16'd32 && pos_r <= 16'd35 && b != 8'(xid >> xid_sh)) rfault_nxt = 1'b1;
    if (pos_r >= 16'd44 && pos_r <= 16'd47) your_nxt = {your_nxt[23:0], b};
    if (pos_r >= 16'd48 && pos_r <= 16'd51) srv_nxt = {srv_nxt[23:0], b};
    if (pos_r >= 16'd52 && pos_r <= 16'd55) relay_nxt = {relay_nxt[23:0], b};
    if (pos_r >= 16'd264 && pos_r <= 16'd267 && b != cookie_byte(pos_r[1:0]))
      cookie_bad_nxt = 1'b1;
    if (pos_r == OPT_START && ph_nxt == PH_IDLE)
      ph_nxt = cookie_bad_nxt ? PH_DONE : PH_CODE;

    if (pos_r >= OPT_START) begin
      case (ph_nxt)
        PH_CODE: begin
          if (pos_r >= tlen_nxt || b == 8'hFF) ph_nxt = PH_DONE;
          else if (b != 8'd0) begin
            code_nxt = b;
            ph_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          opt_end = {1'b0, pos_r} + 17'd1 + {9'd0, b};
          if (opt_end > {1'b0, tlen_nxt}) ph_nxt = PH_DONE;
          else if (b == 8'd0) ph_nxt = PH_CODE;
          else begin
            rem_nxt = b;
            taken_nxt = 3'd0;
            flags_nxt[0] = b >= 8'd4 && code_nxt == 8'd1 && mask_nxt == ALL_ONES;
            flags_nxt[1] = b >= 8'd4 && code_nxt == 8'd3 && gw_nxt == ALL_ONES;
            ph_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (taken_nxt < 3'd4) begin
            if (flags_nxt[0]) mask_nxt = {mask_nxt[23:0], b};
            if (flags_nxt[1]) gw_nxt = {gw_nxt[23:0], b};
            taken_nxt = taken_nxt + 3'd1;
          end
          rem_nxt = rem_nxt - 8'd1;
          if (rem_nxt == 8'd0) begin
            flags_nxt = 2'd0;
            ph_nxt = PH_CODE;
          end
        end
        default: ;
      endcase
    end

    // verdict
    len = {1'b0, pos_r} + 17'd1;
    ulen_p20 = {1'b0, ulen_nxt} + 17'd20;
    if (replied_r) status = ST_REPLIED;
    else if (hfault_nxt || len < 17'd28 || sum_nxt != 17'h0FFFF ||
             len < {1'b0, tlen_nxt} || {1'b0, tlen_nxt} < ulen_p20)
      status = ST_BAD_HDR;
    else if (frag_nxt) status = ST_FRAG;
    else if (ulen_nxt < 16'd308 || rfault_nxt) status = ST_NOT_OURS;
    else status = ST_OK;

    out_nxt = '0;
    out_nxt.status = status;
    replied_nxt = replied_r;
    if (in_ch.data.last_byte && status == ST_OK) begin
      if (gw_nxt == ALL_ONES && relay_nxt != 32'd0) gw_nxt = relay_nxt;
      replied_nxt = 1'b1;
      out_nxt.accepted = 1'b1;
      out_nxt.assigned_ip = your_nxt;
      out_nxt.server_addr = srv_nxt;
      out_nxt.netmask = mask_nxt;
      out_nxt.gateway = gw_nxt;
    end

    if (in_ch.data.last_byte) pos_nxt = 16'd0;
    else if (pos_r != 16'hFFFF) pos_nxt = pos_r + 16'd1;
    else pos_nxt = pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replied_r <= 1'b0;
      pos_r <= '0;
      ph_r <= PH_IDLE;
      ovalid_r <= 1'b0;
      held_r <= '0;
    end else begin
      if (take) begin
        replied_r <= replied_nxt;
        pos_r <= pos_nxt;
        ph_r <= ph_nxt;
        held_r <= b;
      end
      if (take && in_ch.data.last_byte) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sum_r <= sum_nxt; hfault_r <= hfault_nxt; frag_r <= frag_nxt;
      rfault_r <= rfault_nxt; tlen_r <= tlen_nxt; ulen_r <= ulen_nxt;
      your_r <= your_nxt; srv_r <= srv_nxt; relay_r <= relay_nxt;
      mask_r <= mask_nxt; gw_r <= gw_nxt; code_r <= code_nxt;
      rem_r <= rem_nxt; flags_r <= flags_nxt; taken_r <= taken_nxt;
      cookie_bad_r <= cookie_bad_nxt;
      if (in_ch.data.last_byte) out_r <= out_nxt;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data = out_r;

  `BRP_ASSERT_NEXT(a_verdict_follows_last, take && in_ch.data.last_byte,
                   ovalid_r && pos_r == 16'd0, "verdict not raised after last byte")
  `BRP_ASSERT_NEXT(a_stall_holds, ovalid_r && !out_ch.ready,
                   ovalid_r && $stable(out_r), "stalled verdict changed")
  `BRP_ASSERT(a_accept_iff_ok, !ovalid_r || (out_r.accepted == (out_r.status == ST_OK)),
              "accepted disagrees with status")
  `BRP_ASSERT_NEXT(a_replied_sticks, replied_r, replied_r, "reply flag cleared")
endmodule
